// ===== hw/rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with search: shared package
// Request codes, result status codes, controller states and the control
// bundle that the top level drives into every queue cell.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OccW    = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_PUSHED    = 3'd0,
    STS_FULL      = 3'd1,
    STS_POPPED    = 3'd2,
    STS_EMPTY_POP = 3'd3,
    STS_MATCH     = 3'd4,
    STS_NO_MATCH  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    logic                    push_en;
    logic                    pop_en;
    logic                    search_en;
    logic                    scan_en;
    logic signed [DataW-1:0] word;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/fifo_queue_with_search.sv =====
// Push, pop and clear results are registered at the edge that accepts the
// request. A search first marks the matching cells, then shifts the hit
// flags through the head cell, one cell per step, and last gives the final
// result; it stalls while the result register is held. One request is in
// work at a time.
// Reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
// FIFO queue with search: top level
// A bounded queue in a row of cells, head in cell zero. A search marks the
// matching cells at once, then scans the marks one cell per cycle (held while
// a match waits on the output), one result per match or one no-match result.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        op_i,
  input  logic signed [fqs_pkg::DataW-1:0]  data_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fqs_pkg::StatusW-1:0]       status_o,
  output logic [fqs_pkg::PosW-1:0]          match_position_o,
  output logic [fqs_pkg::OccW-1:0]          occupancy_o,
  output logic                              is_empty_o,
  output logic                              last_o
);
  import fqs_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         scan_pos_q, scan_pos_d;
  logic [CntW-1:0]         pend_pos_q, pend_pos_d;
  logic                    pend_valid_q, pend_valid_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic [PosW-1:0]         mpos_q, mpos_d;
  logic [OccW-1:0]         occ_q, occ_d;
  logic                    empty_q, empty_d;
  logic                    last_q, last_d;

  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]        cell_hit;
  logic                    slot_free;
  logic                    accept;
  logic                    full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] nbr_data;
    logic                    nbr_hit;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr_data = cell_data[i];
      assign nbr_hit  = 1'b0;
    end else begin : g_mid
      assign nbr_data = cell_data[i+1];
      assign nbr_hit  = cell_hit[i+1];
    end
    fqs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_sel_i   (CntW'(i) == count_q),
      .occ_i      (CntW'(i) < count_q),
      .nbr_data_i (nbr_data),
      .nbr_hit_i  (nbr_hit),
      .data_o     (cell_data[i]),
      .hit_o      (cell_hit[i])
    );
  end

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_pos_d   = scan_pos_q;
    pend_pos_d   = pend_pos_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    mpos_d       = mpos_q;
    last_d       = last_q;
    ctrl         = '0;
    ctrl.word    = data_word_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          mpos_d      = '0;
          last_d      = 1'b1;
          unique case (op_e'(op_i))
            OP_PUSH: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                ctrl.push_en = 1'b1;
                count_d      = count_q + 1'b1;
                status_d     = STS_PUSHED;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY_POP;
              end else begin
                ctrl.pop_en = 1'b1;
                count_d     = count_q - 1'b1;
                status_d    = STS_POPPED;
              end
            end
            OP_SEARCH: begin
              out_valid_d    = 1'b0;
              ctrl.search_en = 1'b1;
              scan_pos_d     = '0;
              pend_valid_d   = 1'b0;
              state_d        = ST_SCAN;
            end
            OP_CLEAR: begin
              count_d  = '0;
              status_d = STS_PUSHED;
            end
            default: begin
              status_d = STS_PUSHED;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_pos_q == count_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            status_d    = pend_valid_q ? STS_MATCH : STS_NO_MATCH;
            mpos_d      = pend_valid_q ? PosW'(pend_pos_q) : '0;
            last_d      = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (!cell_hit[0] || !pend_valid_q || slot_free) begin
          ctrl.scan_en = 1'b1;
          scan_pos_d   = scan_pos_q + 1'b1;
          if (cell_hit[0]) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              status_d    = STS_MATCH;
              mpos_d      = PosW'(pend_pos_q);
              last_d      = 1'b0;
            end
            pend_pos_d   = scan_pos_q;
            pend_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    occ_d   = OccW'(count_d);
    empty_d = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      scan_pos_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_pos_q   <= scan_pos_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pos_q <= pend_pos_d;
    status_q   <= status_d;
    mpos_q     <= mpos_d;
    occ_q      <= occ_d;
    empty_q    <= empty_d;
    last_q     <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_position_o = mpos_q;
  assign occupancy_o      = occ_q;
  assign is_empty_o       = empty_q;
  assign last_o           = last_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count exceeds its depth");

  a_scan_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !in_ready_o)
    else $error("request taken during a search scan");

  a_empty_pop_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_POP && count_q == '0 |=> count_q == '0)
    else $error("pop on an empty queue changed the count");

  a_nomatch_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != STS_MATCH |-> mpos_q == '0 && last_q)
    else $error("non-match result with a position or not final");
`endif

endmodule

// ===== hw/rtl/fqs_cell.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with search: queue cell
// Holds one entry and its search hit flag. Entries move toward the head on
// a pop, and hit flags move toward the head during a search scan.
// ----------------------------------------------------------------------------
module fqs_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fqs_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           wr_sel_i,
  input  logic                           occ_i,
  input  logic signed [fqs_pkg::DataW-1:0] nbr_data_i,
  input  logic                           nbr_hit_i,
  output logic signed [fqs_pkg::DataW-1:0] data_o,
  output logic                           hit_o
);
  import fqs_pkg::*;

  logic signed [DataW-1:0] data_q;
  logic                    hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push_en && wr_sel_i) begin
      data_q <= ctrl_i.word;
    end else if (ctrl_i.pop_en) begin
      data_q <= nbr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.search_en) begin
      hit_q <= occ_i && (data_q == ctrl_i.word);
    end else if (ctrl_i.scan_en) begin
      hit_q <= nbr_hit_i;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule
